// ----- rtl/core/dns_name_text_to_wire_macros.svh -----
// assertion macros for the dns name text-to-wire block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef DNS_NAME_TEXT_TO_WIRE_MACROS_SVH
`define DNS_NAME_TEXT_TO_WIRE_MACROS_SVH
`ifndef SYNTHESIS
`define DNSTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DNSTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DNSTW_ASSERT_IMP(lbl, ante, cons, msg)
`define DNSTW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/dnstw_pkg.sv -----
// shared types, constants and step functions of the dns name text-to-wire block
// no dependencies
package dnstw_pkg;

  localparam int MaxNameDef  = 255;
  localparam int MaxLabelDef = 63;
  localparam int MaxRes      = 4;
  localparam int CntW        = $clog2(MaxRes + 1);
  localparam int IdxW        = $clog2(MaxRes);

  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharBsl  = 8'h5C;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [9:0] ByteMax  = 10'd255;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_LONG = 2'd2,
    KIND_ESC  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] addr;
    logic [7:0] value;
    logic [7:0] total_len;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [CntW-1:0]   cnt;
  } bundle_t;

  // working copy of the name state while one character is processed
  typedef struct packed {
    logic [8:0] wp;
    logic [7:0] ls;
    logic       fl;
    bundle_t    b;
  } ctx_t;

  function automatic ctx_t emit(ctx_t c, kind_e k, logic [7:0] a, logic [7:0] v,
                                logic [7:0] t, logic l);
    ctx_t r;
    r = c;
    if (r.b.cnt < CntW'(MaxRes)) begin
      r.b.r[r.b.cnt[IdxW-1:0]] = '{kind: k, addr: a, value: v, total_len: t, last: l};
      r.b.cnt = r.b.cnt + CntW'(1);
    end
    return r;
  endfunction

  function automatic ctx_t fail(ctx_t c, kind_e k);
    ctx_t r;
    r = emit(c, k, 8'd0, 8'd0, 8'd0, 1'b1);
    r.fl = 1'b1;
    return r;
  endfunction

  // data byte, too-long error once the buffer is full
  function automatic ctx_t put_byte(ctx_t c, logic [7:0] b, logic [7:0] lim);
    ctx_t r;
    if (c.wp + 9'd1 >= {1'b0, lim}) begin
      r = fail(c, KIND_LONG);
    end else begin
      r = emit(c, KIND_BYTE, c.wp[7:0], b, 8'd0, 1'b0);
      r.wp = c.wp + 9'd1;
    end
    return r;
  endfunction

  // write back the length byte of the label a dot closes, too-long error past the label limit
  function automatic ctx_t close_label(ctx_t c, logic [8:0] max_lab);
    ctx_t       r;
    logic [8:0] len;
    r = c;
    len = c.wp - {1'b0, c.ls};
    if (len > max_lab) begin
      r = fail(c, KIND_LONG);
    end else if (len != 9'd0) begin
      r = emit(c, KIND_BYTE, c.ls - 8'd1, len[7:0], 8'd0, 1'b0);
      r.wp = c.wp + 9'd1;
      r.ls = r.wp[7:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/dnstw_step.sv -----
// name state registers and the per-character decision logic
// depends on dnstw_pkg
module dnstw_step #(
  parameter int MAX_LABEL = dnstw_pkg::MaxLabelDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         ch_i,
  input  logic               end_i,
  input  logic [7:0]         limit_i,
  output dnstw_pkg::bundle_t bundle_o
);

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_SLASH = 2'd1,
    ESC_ONE   = 2'd2,
    ESC_TWO   = 2'd3
  } esc_e;

  localparam logic [8:0] MaxLab = 9'(MAX_LABEL);

  logic [8:0] wpos_q, wpos_d;
  logic [7:0] lstart_q, lstart_d;
  esc_e       phase_q, phase_d;
  logic [6:0] eval_q, eval_d;
  logic       failed_q, failed_d;

  dnstw_pkg::ctx_t c;
  logic            is_end, is_dig, plain;
  logic [3:0]      dig;
  logic [9:0]      ev10;
  logic [8:0]      len;

  assign is_end = end_i || (ch_i == 8'd0);
  assign is_dig = (ch_i >= dnstw_pkg::CharZero) && (ch_i <= dnstw_pkg::CharNine);
  assign dig    = 4'(ch_i - dnstw_pkg::CharZero);
  assign ev10   = (10'(eval_q) << 3) + (10'(eval_q) << 1) + 10'(dig);

  always_comb begin
    c.wp    = wpos_q;
    c.ls    = lstart_q;
    c.fl    = failed_q;
    c.b     = '0;
    phase_d = phase_q;
    eval_d  = eval_q;
    plain   = 1'b0;
    len     = 9'd0;
    if (is_end) begin
      if (!c.fl) begin
        // pending digit escape goes out before the end
        if (phase_q == ESC_ONE || phase_q == ESC_TWO) begin
          c = dnstw_pkg::put_byte(c, {1'b0, eval_q}, limit_i);
        end
        if (!c.fl) begin
          len = c.wp - {1'b0, c.ls};
          if (len > MaxLab) begin
            c = dnstw_pkg::fail(c, dnstw_pkg::KIND_LONG);
          end else begin
            c = dnstw_pkg::emit(c, dnstw_pkg::KIND_BYTE, c.ls - 8'd1, len[7:0], 8'd0, 1'b0);
            if (len != 9'd0) begin
              c = dnstw_pkg::emit(c, dnstw_pkg::KIND_BYTE, c.wp[7:0], 8'd0, 8'd0, 1'b0);
              c.wp = c.wp + 9'd1;
            end
            c = dnstw_pkg::emit(c, dnstw_pkg::KIND_DONE, 8'd0, 8'd0, c.wp[7:0], 1'b1);
          end
        end
      end
      phase_d = ESC_NONE;
      eval_d  = 7'd0;
    end else if (!c.fl) begin
      unique case (phase_q) inside
        ESC_SLASH: begin
          if (is_dig) begin
            eval_d  = 7'(dig);
            phase_d = ESC_ONE;
          end else begin
            phase_d = ESC_NONE;
            c = dnstw_pkg::put_byte(c, ch_i, limit_i);
          end
        end
        ESC_ONE, ESC_TWO: begin
          if (is_dig) begin
            if (phase_q == ESC_ONE) begin
              eval_d  = 7'(ev10);
              phase_d = ESC_TWO;
            end else begin
              phase_d = ESC_NONE;
              if (ev10 > dnstw_pkg::ByteMax) begin
                c = dnstw_pkg::fail(c, dnstw_pkg::KIND_ESC);
              end else begin
                c = dnstw_pkg::put_byte(c, ev10[7:0], limit_i);
              end
            end
          end else begin
            // escape cut short: write it, then treat the character as usual
            phase_d = ESC_NONE;
            c = dnstw_pkg::put_byte(c, {1'b0, eval_q}, limit_i);
            plain = !c.fl;
          end
        end
        default: plain = 1'b1;
      endcase
      if (plain) begin
        if (ch_i == dnstw_pkg::CharDot) begin
          c = dnstw_pkg::close_label(c, MaxLab);
        end else if (ch_i == dnstw_pkg::CharBsl) begin
          phase_d = ESC_SLASH;
        end else begin
          c = dnstw_pkg::put_byte(c, ch_i, limit_i);
        end
      end
    end
    if (is_end) begin
      wpos_d   = 9'd1;
      lstart_d = 8'd1;
      failed_d = 1'b0;
    end else begin
      wpos_d   = c.wp;
      lstart_d = c.ls;
      failed_d = c.fl;
    end
  end

  assign bundle_o = c.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= 9'd1;
      lstart_q <= 8'd1;
      phase_q  <= ESC_NONE;
      eval_q   <= 7'd0;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      wpos_q   <= wpos_d;
      lstart_q <= lstart_d;
      phase_q  <= phase_d;
      eval_q   <= eval_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ----- rtl/core/dnstw_outq.sv -----
// result register: holds the results of one character and hands them out one a cycle while the output is ready
// depends on dnstw_pkg
module dnstw_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dnstw_pkg::bundle_t bundle_i,
  output logic               can_load_o,
  output logic               valid_o,
  input  logic               ready_i,
  output dnstw_pkg::res_t    res_o
);

  dnstw_pkg::res_t [dnstw_pkg::MaxRes-1:0] bund_q;
  logic [dnstw_pkg::CntW-1:0]              rd_q, rd_d;
  logic [dnstw_pkg::CntW-1:0]              cnt_q;
  logic [dnstw_pkg::CntW-1:0]              rd_inc;

  assign rd_inc     = rd_q + dnstw_pkg::CntW'(1);
  assign valid_o    = (rd_q != cnt_q);
  assign can_load_o = !valid_o || (ready_i && (rd_inc == cnt_q));
  assign res_o      = bund_q[rd_q[dnstw_pkg::IdxW-1:0]];

  always_comb begin
    rd_d = rd_q;
    if (valid_o && ready_i) begin
      rd_d = rd_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (load_i) begin
      rd_q  <= '0;
      cnt_q <= bundle_i.cnt;
    end else begin
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bund_q <= bundle_i.r;
    end
  end

endmodule

// ----- rtl/core/dns_name_text_to_wire.sv -----
// top level of the dns name text-to-wire converter
// depends on dnstw_pkg, dnstw_step, dnstw_outq and dns_name_text_to_wire_macros.svh
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata = ch, tlast = end of name
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i addr,value,total_len / kind / last
// cfg       in   cfg_valid_i/cfg_ready_o         cfg_data_i = out_size
//
// a character that causes at most one result is taken every cycle while the output
// is ready; one that causes more results (up to four, at the end of a name) holds
// the input until the last of them is taken, since the result register drains
// through one output port; results appear in the cycle after the character is taken
// reset clears the name state and sets out_size to its maximum
// a stall on the output holds the input while any result of the last character is pending
`include "dns_name_text_to_wire_macros.svh"

module dns_name_text_to_wire #(
  parameter int MAX_NAME  = dnstw_pkg::MaxNameDef,   // 16..255
  parameter int MAX_LABEL = dnstw_pkg::MaxLabelDef   // 1..63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] addr, [15:8] value, [23:16] total_len
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,
  // out_size register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [7:0] MaxName = 8'(MAX_NAME);

  logic               s_fire;
  logic               can_load;
  logic [7:0]         out_size_q;
  logic [7:0]         limit;
  dnstw_pkg::bundle_t bundle;
  dnstw_pkg::res_t    res;

  // out_size register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_size_q <= 8'd255;
    end else if (cfg_valid_i) begin
      out_size_q <= cfg_data_i;
    end
  end

  // usable buffer size: capped at the max name length, zero read as one
  always_comb begin
    if (out_size_q == 8'd0) begin
      limit = 8'd1;
    end else if (out_size_q > MaxName) begin
      limit = MaxName;
    end else begin
      limit = out_size_q;
    end
  end

  // a character is taken once the result register is empty or its last result is taken
  assign s_axis_tready_o = can_load;
  assign s_fire          = s_axis_tvalid_i && can_load;

  dnstw_step #(
    .MAX_LABEL (MAX_LABEL)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s_fire),
    .ch_i     (s_axis_tdata_i),
    .end_i    (s_axis_tlast_i),
    .limit_i  (limit),
    .bundle_o (bundle)
  );

  dnstw_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s_fire),
    .bundle_i   (bundle),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {res.total_len, res.value, res.addr};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

  // done and error results close the name
  `DNSTW_ASSERT_IMP(a_last_on_status,
    m_axis_tvalid_o && (res.kind != dnstw_pkg::KIND_BYTE), m_axis_tlast_o,
    "status result without last")
  // byte writes stay inside the largest buffer
  `DNSTW_ASSERT_IMP(a_addr_in_range,
    m_axis_tvalid_o && (res.kind == dnstw_pkg::KIND_BYTE), res.addr < MaxName,
    "byte write beyond max name length")
  // input stalls only behind a pending result
  `DNSTW_ASSERT_IMP(a_stall_has_cause, !s_axis_tready_o, m_axis_tvalid_o,
    "input stalled with no result pending")

endmodule
